FILE: design/m44i_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m44i_pkg
// Shared types, constants and address helpers of the 4x4 matrix inverse core.
// ----------------------------------------------------------------------------
package m44i_pkg;

  // Width of the flat element index and the index that starts an inversion.
  localparam int unsigned IdxW = 4;
  localparam logic [IdxW-1:0] LastIdx = 4'd15;

  // Multiplier operand bits consumed per cycle by the digit-serial multiplier.
  localparam int unsigned MulDigit = 8;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_COF_FIN,
    ST_DET_CHK,
    ST_SING_LD,
    ST_ADJ_RD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT_LD
  } m44i_state_e;

  // Product kinds of the cofactor and determinant micro-sequence.
  typedef enum logic [1:0] {
    OP_P1,   // first 2x2 product
    OP_P2,   // second 2x2 product, forms the 2x2 minor
    OP_P3,   // 2x2 minor times the top row element of the 3x3 minor
    OP_P4    // row-zero cofactor times its element, adds to the determinant
  } m44i_op_e;

  // Flat address of element (mr, mc) of the 3x3 minor that omits row er and
  // column ec, where the cofactor index holds er in [1:0] and ec in [3:2].
  function automatic logic [IdxW-1:0] minor_addr(input logic [IdxW-1:0] cidx,
                                                 input logic [1:0] mr,
                                                 input logic [1:0] mc);
    logic [1:0] row;
    logic [1:0] col;
    row = (mr >= cidx[1:0]) ? (mr + 2'd1) : mr;
    col = (mc >= cidx[3:2]) ? (mc + 2'd1) : mc;
    return {row, col};
  endfunction

endpackage

FILE: design/m44i_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m44i_mul
// Digit-serial signed multiplier, most significant multiplier digit first.
// ----------------------------------------------------------------------------
module m44i_mul import m44i_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [3*W+2:0]     a_i,
  input  logic signed [W-1:0]       b_i,
  output logic                      done_o,
  output logic signed [4*W+2:0]     p_o
);

  localparam int unsigned MAW  = 3 * W + 3;
  localparam int unsigned PW   = MAW + W;
  localparam int unsigned NDIG = (W + MulDigit - 1) / MulDigit;
  localparam int unsigned BW   = NDIG * MulDigit;
  localparam int unsigned CNTW = $clog2(NDIG + 1);

  logic signed [MAW-1:0]          a_q;
  logic [BW-1:0]                  b_q;
  logic signed [PW-1:0]           acc_q;
  logic [CNTW-1:0]                cnt_q;
  logic                           first_q;
  logic                           done_q;
  logic [MulDigit-1:0]            digit;
  logic signed [MulDigit:0]       sdig;
  logic signed [MAW+MulDigit:0]   pp;
  logic signed [PW-1:0]           acc_d;

  // The top digit carries the sign of the multiplier; the others are unsigned.
  always_comb begin
    digit = b_q[BW-1 -: MulDigit];
    sdig  = $signed({first_q ? digit[MulDigit-1] : 1'b0, digit});
    pp    = a_q * sdig;
    acc_d = (acc_q <<< MulDigit) + PW'(pp);
  end

  // Control: digit counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNTW'(NDIG);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: one digit accumulated per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q     <= a_i;
      b_q     <= BW'(b_i);
      acc_q   <= '0;
      first_q <= 1'b1;
    end else if (cnt_q != '0) begin
      acc_q   <= acc_d;
      b_q     <= b_q << MulDigit;
      first_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

FILE: design/m44i_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m44i_div
// Restoring divider: cofactor scaled by 2^(2F) over the determinant,
// truncated toward zero and saturated to a signed W-bit result.
// ----------------------------------------------------------------------------
module m44i_div #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [3*W+2:0]     num_i,
  input  logic signed [4*W+4:0]     den_i,
  output logic                      done_o,
  output logic [W-1:0]              quot_o
);

  localparam int unsigned CW   = 3 * W + 3;
  localparam int unsigned DW   = 4 * W + 5;
  localparam int unsigned NW   = CW + 2 * F;
  localparam int unsigned SW   = DW + W + 1;
  localparam int unsigned DVW  = ((NW > SW) ? NW : SW) + 1;
  localparam int unsigned QW   = W + 1;
  localparam int unsigned CNTW = $clog2(QW + 1);

  logic [CW-1:0]   num_mag;
  logic [DW-1:0]   den_mag;
  logic [DVW-1:0]  a_ext;
  logic [DVW-1:0]  b_ext;
  logic [DVW-1:0]  r_q;
  logic [DVW-1:0]  bs_q;
  logic [QW-1:0]   q_q;
  logic [CNTW-1:0] cnt_q;
  logic            neg_q;
  logic            big_q;
  logic            done_q;
  logic            ge;
  logic [W-1:0]    lim;

  // Magnitudes of the operands, numerator pre-scaled.
  always_comb begin
    num_mag = num_i[CW-1] ? (~$unsigned(num_i) + 1'b1) : $unsigned(num_i);
    den_mag = den_i[DW-1] ? (~$unsigned(den_i) + 1'b1) : $unsigned(den_i);
    a_ext   = DVW'(num_mag) << (2 * F);
    b_ext   = DVW'(den_mag);
    ge      = (r_q >= bs_q);
  end

  // Control: quotient bit counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNTW'(QW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: a quotient too large for W+1 bits is flagged at start, then
  // one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= a_ext;
      bs_q  <= b_ext << W;
      q_q   <= '0;
      neg_q <= num_i[CW-1] ^ den_i[DW-1];
      big_q <= (a_ext >= (b_ext << QW));
    end else if (cnt_q != '0) begin
      r_q  <= ge ? (r_q - bs_q) : r_q;
      q_q  <= {q_q[QW-2:0], ge};
      bs_q <= bs_q >> 1;
    end
  end

  // Sign and saturation to the signed W-bit range.
  always_comb begin
    lim = {1'b1, {(W-1){1'b0}}};
    if (neg_q) begin
      if (big_q || q_q[W] || (q_q[W-1:0] > lim)) begin
        quot_o = lim;
      end else begin
        quot_o = ~q_q[W-1:0] + 1'b1;
      end
    end else begin
      if (big_q || q_q[W] || q_q[W-1]) begin
        quot_o = ~lim;
      end else begin
        quot_o = q_q[W-1:0];
      end
    end
  end

  assign done_o = done_q;

endmodule

FILE: design/matrix4x4_inverse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4x4_inverse_core
// 4x4 fixed-point matrix inverse by adjugate and determinant.
//
// Channel   Dir  Handshake                tdata (low bit up)            side
// s_axis    in   s_axis_tvalid/tready     element_value, element_index  -
// m_axis    out  m_axis_tvalid/tready     result_value, result_index    tuser=singular,
//                                                                       tlast=last
//
// The beat with index 15 starts the run. The cofactor pass runs on the one
// shared digit-serial multiplier, then each of the sixteen results goes
// through the restoring divider. Reset clears the sequencer and the output
// valid flag; the output payload and the element and adjugate memories hold
// no reset value. The input takes beats only while idle; the output register
// holds a result until the sink takes it.
// ----------------------------------------------------------------------------
module matrix4x4_inverse_core import m44i_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // element_value [VALUE_WIDTH-1:0], element_index [VALUE_WIDTH+3:VALUE_WIDTH]
  input  logic [((VALUE_WIDTH+IdxW+7)/8)*8-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // result_value [VALUE_WIDTH-1:0], result_index [VALUE_WIDTH+3:VALUE_WIDTH]
  output logic [((VALUE_WIDTH+IdxW+7)/8)*8-1:0] m_axis_tdata,
  // singular [0]
  output logic                      m_axis_tuser,
  output logic                      m_axis_tlast
);

  localparam int unsigned W   = VALUE_WIDTH;
  localparam int unsigned CW  = 3 * W + 3;
  localparam int unsigned DW  = 4 * W + 5;
  localparam int unsigned PW  = CW + W;
  localparam int unsigned TDW = ((W + IdxW + 7) / 8) * 8;

  m44i_state_e state_q, state_d;
  m44i_op_e    op_q, op_d;
  logic [IdxW-1:0] cidx_q, cidx_d;
  logic [1:0]      term_q, term_d;

  logic signed [W-1:0]    mat_mem [16];
  logic signed [CW-1:0]   adj_mem [16];
  logic signed [W-1:0]    mat_rdata_q;
  logic signed [CW-1:0]   adj_rdata_q;
  logic [IdxW-1:0]        mat_raddr;

  logic signed [2*W-1:0]  prod1_q;
  logic signed [2*W:0]    diff_q;
  logic signed [CW-1:0]   cof_q;
  logic signed [CW-1:0]   cof_fin;
  logic signed [DW-1:0]   det_q;
  logic signed [CW-1:0]   opa_q;

  logic                   mul_start;
  logic                   mul_done;
  logic signed [PW-1:0]   mul_p;
  logic                   div_start;
  logic                   div_done;
  logic [W-1:0]           div_quot;

  logic                   in_fire;
  logic [IdxW-1:0]        in_idx;
  logic                   out_free;
  logic                   out_load;
  logic                   sing_load;
  logic                   clr_cof;
  logic                   clr_det;
  logic [1:0]             xc;
  logic [1:0]             yc;

  logic                   out_valid_q;
  logic [W-1:0]           out_value_q;
  logic [IdxW-1:0]        out_index_q;
  logic                   out_sing_q;
  logic                   out_last_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_idx        = s_axis_tdata[W+IdxW-1:W];
  assign out_free      = !out_valid_q || m_axis_tready;

  // Cofactor sign follows the parity of row plus column.
  assign cof_fin = (cidx_q[0] ^ cidx_q[2]) ? -cof_q : cof_q;

  // Minor column picks for the 2x2 minor of the current term.
  assign xc = (term_q == 2'd0) ? 2'd1 : 2'd0;
  assign yc = (term_q == 2'd2) ? 2'd1 : 2'd2;

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_P1;
      cidx_q  <= '0;
      term_q  <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cidx_q  <= cidx_d;
      term_q  <= term_d;
    end
  end

  // Next state, read addresses and unit strobes.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    cidx_d    = cidx_q;
    term_d    = term_q;
    mat_raddr = '0;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    sing_load = 1'b0;
    clr_cof   = 1'b0;
    clr_det   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_idx == LastIdx)) begin
          state_d = ST_RD_A;
          op_d    = OP_P1;
          cidx_d  = '0;
          term_d  = '0;
          clr_cof = 1'b1;
          clr_det = 1'b1;
        end
      end
      ST_RD_A: begin
        case (op_q)
          OP_P1:   mat_raddr = minor_addr(cidx_q, 2'd1, xc);
          OP_P2:   mat_raddr = minor_addr(cidx_q, 2'd1, yc);
          default: mat_raddr = '0;
        endcase
        state_d = ST_RD_B;
      end
      ST_RD_B: begin
        case (op_q)
          OP_P1:   mat_raddr = minor_addr(cidx_q, 2'd2, yc);
          OP_P2:   mat_raddr = minor_addr(cidx_q, 2'd2, xc);
          OP_P3:   mat_raddr = minor_addr(cidx_q, 2'd0, term_q);
          default: mat_raddr = {2'b00, cidx_q[3:2]};
        endcase
        state_d = ST_MUL_GO;
      end
      ST_MUL_GO: begin
        mul_start = 1'b1;
        state_d   = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          case (op_q)
            OP_P1: begin
              op_d    = OP_P2;
              state_d = ST_RD_A;
            end
            OP_P2: begin
              op_d    = OP_P3;
              state_d = ST_RD_A;
            end
            OP_P3: begin
              if (term_q == 2'd2) begin
                state_d = ST_COF_FIN;
              end else begin
                term_d  = term_q + 2'd1;
                op_d    = OP_P1;
                state_d = ST_RD_A;
              end
            end
            default: begin
              // Determinant term done; move to the next cofactor.
              if (cidx_q == LastIdx) begin
                state_d = ST_DET_CHK;
              end else begin
                cidx_d  = cidx_q + 1'b1;
                term_d  = '0;
                op_d    = OP_P1;
                clr_cof = 1'b1;
                state_d = ST_RD_A;
              end
            end
          endcase
        end
      end
      ST_COF_FIN: begin
        if (cidx_q[1:0] == 2'd0) begin
          // Row-zero cofactor also feeds the determinant.
          op_d    = OP_P4;
          state_d = ST_RD_A;
        end else if (cidx_q == LastIdx) begin
          state_d = ST_DET_CHK;
        end else begin
          cidx_d  = cidx_q + 1'b1;
          term_d  = '0;
          op_d    = OP_P1;
          clr_cof = 1'b1;
          state_d = ST_RD_A;
        end
      end
      ST_DET_CHK: begin
        cidx_d = '0;
        if (det_q == '0) begin
          state_d = ST_SING_LD;
        end else begin
          state_d = ST_ADJ_RD;
        end
      end
      ST_SING_LD: begin
        if (out_free) begin
          sing_load = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_ADJ_RD: begin
        state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = ST_OUT_LD;
        end
      end
      ST_OUT_LD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (cidx_q == LastIdx) begin
            state_d = ST_IDLE;
          end else begin
            cidx_d  = cidx_q + 1'b1;
            state_d = ST_ADJ_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Element memory: written while loading and read every cycle, but the reads
  // are used only while computing, when no writes come in.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mat_mem[in_idx] <= s_axis_tdata[W-1:0];
    end
    mat_rdata_q <= mat_mem[mat_raddr];
  end

  // Adjugate memory: written at the end of each cofactor, read for division.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_COF_FIN) begin
      adj_mem[cidx_q] <= cof_fin;
    end
    adj_rdata_q <= adj_mem[cidx_q];
  end

  // Product accumulation for minors, cofactors and the determinant.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD_B) begin
      case (op_q)
        OP_P1, OP_P2: opa_q <= CW'(mat_rdata_q);
        OP_P3:        opa_q <= CW'(diff_q);
        default:      opa_q <= cof_q;
      endcase
    end
    if ((state_q == ST_MUL_WAIT) && mul_done) begin
      case (op_q)
        OP_P1:   prod1_q <= mul_p[2*W-1:0];
        OP_P2:   diff_q  <= (2*W+1)'(prod1_q) - (2*W+1)'($signed(mul_p[2*W-1:0]));
        OP_P3:   cof_q   <= term_q[0] ? (cof_q - $signed(mul_p[CW-1:0]))
                                      : (cof_q + $signed(mul_p[CW-1:0]));
        default: det_q   <= det_q + DW'(mul_p);
      endcase
    end
    if (clr_cof) begin
      cof_q <= '0;
    end else if (state_q == ST_COF_FIN) begin
      cof_q <= cof_fin;
    end
    if (clr_det) begin
      det_q <= '0;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load || sing_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= div_quot;
      out_index_q <= cidx_q;
      out_sing_q  <= 1'b0;
      out_last_q  <= (cidx_q == LastIdx);
    end else if (sing_load) begin
      out_value_q <= '0;
      out_index_q <= '0;
      out_sing_q  <= 1'b1;
      out_last_q  <= 1'b1;
    end
  end

  m44i_mul #(
    .W (W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (opa_q),
    .b_i     (mat_rdata_q),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  m44i_div #(
    .W (W),
    .F (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (adj_rdata_q),
    .den_i   (det_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDW'({out_index_q, out_value_q});
  assign m_axis_tuser  = out_sing_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 4x4 fixed-point matrix inverse core.
//
// Element beats are streamed in from a queue that an initial block fills:
// first a short directed set, then random matrices, each one written whole or
// in part. The bench keeps its own copy of the element store. On every beat
// with index 15 it predicts the inverse, or the singular flag, with exact wide
// arithmetic. Each output beat is compared field by field with the oldest
// prediction, while both sides idle and stall in changing phases.
// ----------------------------------------------------------------------------
module testbench;
  import m44i_pkg::*;

  localparam int unsigned VW = 32;
  localparam int unsigned FB = 16;
  localparam int unsigned DW = ((VW + IdxW + 7) / 8) * 8;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned TargetBeats = 320;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic [VW-1:0]   val;
    logic [IdxW-1:0] idx;
    bit              hold;  // pause until every result has come back
  } elem_beat_t;

  typedef struct {
    logic [VW-1:0]   val;
    logic [IdxW-1:0] idx;
    logic            sing;
    logic            last;
  } inv_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  elem_beat_t  elem_queue[$];
  inv_result_t inverse_queue[$];
  elem_beat_t  beat_on_bus;
  logic signed [VW-1:0] elem_shadow[16];

  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned inversions = 0;
  int unsigned singular_runs = 0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  matrix4x4_inverse_core #(.VALUE_WIDTH(VW), .FRAC_BITS(FB)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // element_value [31:0], element_index [35:32]
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // result_value [31:0], result_index [35:32]
    .m_axis_tdata  (m_axis_tdata),
    // singular [0]
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Signed cofactor of element (er, ec), exact.
  function automatic wide_t cofactor_of(input int er, input int ec);
    wide_t m[3][3];
    wide_t d;
    int    rr;
    int    cc;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rr = (r >= er) ? r + 1 : r;
        cc = (c >= ec) ? c + 1 : c;
        m[r][c] = elem_shadow[rr * 4 + cc];
      end
    end
    d = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
      - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
      + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
    return ((er + ec) % 2 == 1) ? -d : d;
  endfunction

  // Store one element and, on index 15, queue the expected inverse.
  task automatic predict_inverse(input elem_beat_t b);
    wide_t adj[16];
    wide_t det;
    wide_t quo;
    wide_t hi_lim;
    wide_t lo_lim;
    inv_result_t res;
    hi_lim = (wide_t'(1) <<< (VW - 1)) - 1;
    lo_lim = -(wide_t'(1) <<< (VW - 1));
    elem_shadow[b.idx] = b.val;
    if (b.idx != LastIdx) return;
    inversions++;
    for (int i = 0; i < 16; i++) adj[i] = cofactor_of(i % 4, i / 4);
    det = '0;
    for (int c = 0; c < 4; c++) det = det + wide_t'(elem_shadow[c]) * adj[c * 4];
    if (det == 0) begin
      singular_runs++;
      res = '{val: '0, idx: '0, sing: 1'b1, last: 1'b1};
      inverse_queue.push_back(res);
      return;
    end
    for (int i = 0; i < 16; i++) begin
      quo = (adj[i] <<< (2 * FB)) / det;
      if (quo > hi_lim) quo = hi_lim;
      if (quo < lo_lim) quo = lo_lim;
      res = '{val: quo[VW-1:0], idx: IdxW'(i), sing: 1'b0, last: (i == 15)};
      inverse_queue.push_back(res);
    end
  endtask

  // Idling phase follows the number of results seen so far.
  function automatic int unsigned sender_idle_pct();
    case ((results_seen / 48) % 4)
      1: return 82;
      3: return 13;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned sink_stall_pct();
    case ((results_seen / 48) % 4)
      2: return 82;
      3: return 13;
      default: return 0;
    endcase
  endfunction

  // Driver: presents queued element beats.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_inverse(beat_on_bus);
        beats_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        while (elem_queue.size() > 0 && elem_queue[0].hold && inverse_queue.size() == 0)
          void'(elem_queue.pop_front());
        if (elem_queue.size() > 0 && !elem_queue[0].hold &&
            $urandom_range(99) >= sender_idle_pct()) begin
          beat_on_bus = elem_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= DW'({beat_on_bus.idx, beat_on_bus.val});
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and drives the sink ready.
  always @(posedge clk_i) begin
    inv_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (inverse_queue.size() == 0) begin
          $error("unexpected result beat: value %h index %0d", m_axis_tdata[VW-1:0],
                 m_axis_tdata[VW+IdxW-1:VW]);
          error_count++;
        end else begin
          want = inverse_queue.pop_front();
          if (m_axis_tdata[VW-1:0] !== want.val) begin
            $error("result_value: expected %h, got %h", want.val, m_axis_tdata[VW-1:0]);
            error_count++;
          end
          if (m_axis_tdata[VW+IdxW-1:VW] !== want.idx) begin
            $error("result_index: expected %0d, got %0d", want.idx,
                   m_axis_tdata[VW+IdxW-1:VW]);
            error_count++;
          end
          if (m_axis_tuser !== want.sing) begin
            $error("singular: expected %b, got %b", want.sing, m_axis_tuser);
            error_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %b, got %b", want.last, m_axis_tlast);
            error_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct());
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_beat(input logic [VW-1:0] v, input logic [IdxW-1:0] i);
    elem_queue.push_back('{val: v, idx: i, hold: 1'b0});
  endtask

  function automatic logic [VW-1:0] random_elem();
    logic [VW-1:0] pick[5];
    pick = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff};
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return VW'($urandom_range(1 << 19) - (1 << 18));
      6, 7: return $urandom;
      8: return VW'(($urandom_range(8) - 4) <<< FB);
      default: return pick[$urandom_range(4)];
    endcase
  endfunction

  // A whole matrix in shuffled order with index 15 last; some rows repeat.
  task automatic add_matrix();
    logic [VW-1:0] vals[16];
    int            order[15];
    int            j;
    int            t;
    bit            dup;
    dup = ($urandom_range(9) == 0);
    for (int i = 0; i < 16; i++) vals[i] = random_elem();
    if (dup) for (int c = 0; c < 4; c++) vals[8 + c] = vals[4 + c];
    for (int i = 0; i < 15; i++) order[i] = i;
    for (int i = 14; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < 15; i++) add_beat(vals[order[i]], IdxW'(order[i]));
    add_beat(vals[15], LastIdx);
  endtask

  // Stimulus and end of run.
  initial begin
    int n;
    // Identity matrix.
    for (int i = 0; i < 16; i++) add_beat((i % 5 == 0) ? VW'(1 << FB) : '0, IdxW'(i));
    // Most negative corner element.
    add_beat(32'h8000_0000, 4'd0);
    add_beat(32'h0001_0000, LastIdx);
    // Zero top row: singular.
    add_beat('0, 4'd0);
    add_beat(32'h7fff_ffff, LastIdx);
    // Tiny diagonal: quotients saturate high, then low.
    add_beat(32'h1, 4'd0);
    add_beat(32'h1, 4'd5);
    add_beat(32'h1, 4'd10);
    add_beat(32'h1, LastIdx);
    add_beat(32'hffff_ffff, 4'd0);
    add_beat(32'h1, LastIdx);
    elem_queue.push_back('{val: '0, idx: '0, hold: 1'b1});
    n = elem_queue.size();
    while (n < TargetBeats) begin
      if ($urandom_range(3) == 0) begin
        for (int k = $urandom_range(3); k > 0; k--) begin
          add_beat(random_elem(), IdxW'($urandom_range(14)));
          n++;
        end
        add_beat(random_elem(), LastIdx);
        n++;
      end else begin
        add_matrix();
        n += 16;
      end
      if (n > 160 && n <= 176) elem_queue.push_back('{val: '0, idx: '0, hold: 1'b1});
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (elem_queue.size() == 0 && !s_axis_tvalid);
    wait (inverse_queue.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("%0d element beats sent, %0d inversions (%0d singular), %0d results checked",
             beats_sent, inversions, singular_runs, results_seen);
    $display("idling phases covered free flow, sender gaps, sink stalls and both");
    if (error_count == 0 && inverse_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
